// ===== hdl/jtfk_pkg.sv =====
// Shared types, constants and saturation helper for the joint TRS forward kinematics core.
package jtfk_pkg;

   localparam int NUM_Q_PRODS = 9;
   localparam int NUM_WORDS   = 12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUAT,
      ST_LOC,
      ST_LOAD,
      ST_MODEL,
      ST_STORE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      KIND_QUAT,
      KIND_LOC,
      KIND_MODEL
   } kind_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/joint_trs_forward_kinematics_core.sv =====
// Top level: sequenced forward kinematics of TRS joints around one shared multiplier.
//
// One joint at a time: the core takes a new joint only after the previous result has been
// taken. Each joint needs nine quaternion products, nine scale products and, for a child joint,
// twelve parent-matrix reads and thirty-six matrix products, all on one 32x32 multiplier with
// one registered stage, then writes the twelve words of the model matrix into the joint store.
// The joint store is not cleared; a parent is only read when its index is below the current
// joint, which has been written.
module joint_trs_forward_kinematics_core #(
   parameter int MAX_JOINTS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [8:0]  req_parent_index,
   input  logic signed [31:0] req_trans_x,
   input  logic signed [31:0] req_trans_y,
   input  logic signed [31:0] req_trans_z,
   input  logic signed [15:0] req_rot_x,
   input  logic signed [15:0] req_rot_y,
   input  logic signed [15:0] req_rot_z,
   input  logic signed [15:0] req_rot_w,
   input  logic signed [31:0] req_scale_x,
   input  logic signed [31:0] req_scale_y,
   input  logic signed [31:0] req_scale_z,
   input  logic               req_last_joint,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_m00,
   output logic signed [31:0] rsp_m01,
   output logic signed [31:0] rsp_m02,
   output logic signed [31:0] rsp_m03,
   output logic signed [31:0] rsp_m10,
   output logic signed [31:0] rsp_m11,
   output logic signed [31:0] rsp_m12,
   output logic signed [31:0] rsp_m13,
   output logic signed [31:0] rsp_m20,
   output logic signed [31:0] rsp_m21,
   output logic signed [31:0] rsp_m22,
   output logic signed [31:0] rsp_m23
);
   import jtfk_pkg::*;

   localparam int JW    = (MAX_JOINTS > 2) ? $clog2(MAX_JOINTS) : 1;
   localparam int DEPTH = MAX_JOINTS * NUM_WORDS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = (JW > 8) ? JW : 8;
   localparam logic [JW-1:0] LAST_IDX = JW'(MAX_JOINTS - 1);
   localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

   state_type state_ff, state_in;

   logic [JW-1:0]            joint_ff;
   logic [3:0]               cnt_ff;
   logic [1:0]               r_ff, c_ff, k_ff;
   logic                     drain_ff;
   logic                     has_parent_ff;
   logic                     last_ff;
   logic [7:0]               parent_ff;
   logic signed [15:0]       q_ff [4];
   logic signed [31:0]       s_ff [3];
   logic signed [31:0]       qp_ff [NUM_Q_PRODS];
   logic signed [31:0]       lfull_ff [NUM_WORDS];
   logic signed [31:0]       p_ff [NUM_WORDS];
   logic signed [31:0]       res_ff [NUM_WORDS];
   logic signed [65:0]       acc_ff;
   logic signed [63:0]       prod_ff;
   logic                     pv_ff;
   kind_type                 pkind_ff;
   logic [3:0]               pcnt_ff;
   logic [1:0]               pr_ff, pc_ff, pk_ff;
   logic signed [31:0]       rd_data_ff;
   logic signed [31:0]       mem [DEPTH];

   logic                     mul_en;
   kind_type                 mul_kind;
   logic signed [31:0]       mul_a, mul_b;
   logic                     rd_en, wr_en;
   logic [AW-1:0]            rd_addr, wr_addr;
   logic                     phase_end;
   logic signed [35:0]       r28 [3][3];
   logic signed [23:0]       rot [3][3];
   logic signed [65:0]       acc_sum, mdl_round;
   logic signed [63:0]       loc_round;
   logic                     accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // Rotation matrix in Q8.28, rounded to Q8.16.
   always_comb begin
      r28[0][0] = ONE_Q28 - 36'sd2 * (36'(qp_ff[1]) + 36'(qp_ff[2]));
      r28[0][1] = 36'sd2 * (36'(qp_ff[3]) - 36'(qp_ff[8]));
      r28[0][2] = 36'sd2 * (36'(qp_ff[4]) + 36'(qp_ff[7]));
      r28[1][0] = 36'sd2 * (36'(qp_ff[3]) + 36'(qp_ff[8]));
      r28[1][1] = ONE_Q28 - 36'sd2 * (36'(qp_ff[0]) + 36'(qp_ff[2]));
      r28[1][2] = 36'sd2 * (36'(qp_ff[5]) - 36'(qp_ff[6]));
      r28[2][0] = 36'sd2 * (36'(qp_ff[4]) - 36'(qp_ff[7]));
      r28[2][1] = 36'sd2 * (36'(qp_ff[5]) + 36'(qp_ff[6]));
      r28[2][2] = ONE_Q28 - 36'sd2 * (36'(qp_ff[0]) + 36'(qp_ff[1]));
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            rot[r][c] = 24'((r28[r][c] + 36'sd2048) >>> 12);
         end
      end
   end

   assign phase_end = (state_ff == ST_QUAT) ? (cnt_ff == 4'd9) : drain_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_QUAT;
         ST_QUAT:  if (phase_end) state_in = ST_LOC;
         ST_LOC:   if (phase_end) state_in = has_parent_ff ? ST_LOAD : ST_STORE;
         ST_LOAD:  if (cnt_ff == 4'd12) state_in = ST_MODEL;
         ST_MODEL: if (phase_end) state_in = ST_STORE;
         ST_STORE: if (cnt_ff == 4'd11) state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_en   = 1'b0;
      mul_kind = KIND_QUAT;
      mul_a    = '0;
      mul_b    = '0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      rd_addr  = AW'({parent_ff, 3'b000}) + AW'({parent_ff, 2'b00}) + AW'(cnt_ff);
      wr_addr  = AW'({joint_ff, 3'b000}) + AW'({joint_ff, 2'b00}) + AW'(cnt_ff);
      unique case (state_ff)
         ST_QUAT: begin
            mul_en = (cnt_ff < 4'd9);
            unique case (cnt_ff)
               4'd0:    begin mul_a = 32'(q_ff[0]); mul_b = 32'(q_ff[0]); end
               4'd1:    begin mul_a = 32'(q_ff[1]); mul_b = 32'(q_ff[1]); end
               4'd2:    begin mul_a = 32'(q_ff[2]); mul_b = 32'(q_ff[2]); end
               4'd3:    begin mul_a = 32'(q_ff[0]); mul_b = 32'(q_ff[1]); end
               4'd4:    begin mul_a = 32'(q_ff[0]); mul_b = 32'(q_ff[2]); end
               4'd5:    begin mul_a = 32'(q_ff[1]); mul_b = 32'(q_ff[2]); end
               4'd6:    begin mul_a = 32'(q_ff[3]); mul_b = 32'(q_ff[0]); end
               4'd7:    begin mul_a = 32'(q_ff[3]); mul_b = 32'(q_ff[1]); end
               4'd8:    begin mul_a = 32'(q_ff[3]); mul_b = 32'(q_ff[2]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_LOC: begin
            mul_en   = !drain_ff;
            mul_kind = KIND_LOC;
            mul_a    = 32'(rot[r_ff][c_ff]);
            mul_b    = s_ff[c_ff];
         end
         ST_LOAD: begin
            rd_en = (cnt_ff < 4'd12);
         end
         ST_MODEL: begin
            mul_en   = !drain_ff;
            mul_kind = KIND_MODEL;
            mul_a    = p_ff[{r_ff, k_ff}];
            mul_b    = lfull_ff[{k_ff, c_ff}];
         end
         ST_STORE: begin
            wr_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign loc_round = (prod_ff + 64'sd32768) >>> 16;
   assign acc_sum   = ((pk_ff == 2'd0) ? 66'sd0 : acc_ff) + 66'(prod_ff);
   assign mdl_round = ((acc_sum + 66'sd32768) >>> 16)
                      + ((pc_ff == 2'd3) ? 66'(p_ff[{pr_ff, 2'd3}]) : 66'sd0);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= res_ff[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         joint_ff <= '0;
         cnt_ff   <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
         drain_ff <= 1'b0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= mul_en;
         if (state_ff != state_in) begin
            cnt_ff   <= '0;
            r_ff     <= '0;
            c_ff     <= '0;
            k_ff     <= '0;
            drain_ff <= 1'b0;
         end else if (state_ff == ST_LOC) begin
            if (c_ff == 2'd2) begin
               c_ff <= '0;
               r_ff <= r_ff + 2'd1;
               if (r_ff == 2'd2) drain_ff <= 1'b1;
            end else begin
               c_ff <= c_ff + 2'd1;
            end
         end else if (state_ff == ST_MODEL) begin
            if (k_ff == 2'd2) begin
               k_ff <= '0;
               if (c_ff == 2'd3) begin
                  c_ff <= '0;
                  r_ff <= r_ff + 2'd1;
                  if (r_ff == 2'd2) drain_ff <= 1'b1;
               end else begin
                  c_ff <= c_ff + 2'd1;
               end
            end else begin
               k_ff <= k_ff + 2'd1;
            end
         end else begin
            cnt_ff <= cnt_ff + 4'd1;
         end
         if (state_ff == ST_STORE && cnt_ff == 4'd11) begin
            if (last_ff || joint_ff == LAST_IDX) begin
               joint_ff <= '0;
            end else begin
               joint_ff <= joint_ff + JW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         parent_ff     <= req_parent_index[7:0];
         has_parent_ff <= !req_parent_index[8]
                          && (CW'(req_parent_index[7:0]) < CW'(joint_ff));
         last_ff       <= req_last_joint;
         q_ff[0]       <= req_rot_x;
         q_ff[1]       <= req_rot_y;
         q_ff[2]       <= req_rot_z;
         q_ff[3]       <= req_rot_w;
         s_ff[0]       <= req_scale_x;
         s_ff[1]       <= req_scale_y;
         s_ff[2]       <= req_scale_z;
         lfull_ff[3]   <= req_trans_x;
         lfull_ff[7]   <= req_trans_y;
         lfull_ff[11]  <= req_trans_z;
         res_ff[3]     <= req_trans_x;
         res_ff[7]     <= req_trans_y;
         res_ff[11]    <= req_trans_z;
      end
      prod_ff  <= mul_a * mul_b;
      pkind_ff <= mul_kind;
      pcnt_ff  <= cnt_ff;
      pr_ff    <= r_ff;
      pc_ff    <= c_ff;
      pk_ff    <= k_ff;
      if (state_ff == ST_LOAD && cnt_ff != 4'd0) begin
         p_ff[cnt_ff - 4'd1] <= rd_data_ff;
      end
      if (pv_ff) begin
         unique case (pkind_ff)
            KIND_QUAT: begin
               qp_ff[pcnt_ff] <= prod_ff[31:0];
            end
            KIND_LOC: begin
               lfull_ff[{pr_ff, pc_ff}] <= sat32(66'(loc_round));
               res_ff[{pr_ff, pc_ff}]   <= sat32(66'(loc_round));
            end
            KIND_MODEL: begin
               acc_ff <= acc_sum;
               if (pk_ff == 2'd2) begin
                  res_ff[{pr_ff, pc_ff}] <= sat32(mdl_round);
               end
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
   end

   assign rsp_m00 = res_ff[0];
   assign rsp_m01 = res_ff[1];
   assign rsp_m02 = res_ff[2];
   assign rsp_m03 = res_ff[3];
   assign rsp_m10 = res_ff[4];
   assign rsp_m11 = res_ff[5];
   assign rsp_m12 = res_ff[6];
   assign rsp_m13 = res_ff[7];
   assign rsp_m20 = res_ff[8];
   assign rsp_m21 = res_ff[9];
   assign rsp_m22 = res_ff[10];
   assign rsp_m23 = res_ff[11];

endmodule

// ===== tb/joint_trs_forward_kinematics_core_test.sv =====
// Self-checking testbench for the joint TRS forward kinematics core.
`timescale 1ns / 100ps

module joint_trs_forward_kinematics_core_test;
   import jtfk_pkg::*;

   localparam int JOINT_COUNT = 256;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic signed [8:0]  parent;
      logic signed [31:0] trans [3];
      logic signed [15:0] quat [4];
      logic signed [31:0] scale [3];
      logic               last;
   } joint_type;

   typedef logic [NUM_WORDS-1:0][31:0] pose_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [8:0]  req_parent_index = '0;
   logic signed [31:0] req_trans_x = '0, req_trans_y = '0, req_trans_z = '0;
   logic signed [15:0] req_rot_x = '0, req_rot_y = '0, req_rot_z = '0, req_rot_w = '0;
   logic signed [31:0] req_scale_x = '0, req_scale_y = '0, req_scale_z = '0;
   logic               req_last_joint = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_m00, rsp_m01, rsp_m02, rsp_m03, rsp_m10, rsp_m11;
   logic signed [31:0] rsp_m12, rsp_m13, rsp_m20, rsp_m21, rsp_m22, rsp_m23;

   pose_type           pending_poses [$];
   logic signed [31:0] pose_store [JOINT_COUNT][NUM_WORDS];
   logic [7:0]         joint_idx = '0;
   int                 mismatches = 0;
   int                 cycles = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 hold_cycles = 0;

   joint_trs_forward_kinematics_core #(.MAX_JOINTS(JOINT_COUNT)) dut (.*);

   always #2 clock = ~clock;

   function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -128'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic pose_type compose_model_matrix(input joint_type j);
      longint             x, y, z, w, one;
      longint             r28 [3][3];
      logic signed [31:0] loc [3][4];
      logic signed [31:0] res [3][4];
      logic signed [127:0] acc, pv, lv;
      pose_type           pose;
      x = j.quat[0];
      y = j.quat[1];
      z = j.quat[2];
      w = j.quat[3];
      one = 64'sd1 << 28;
      r28[0][0] = one - 2 * (y * y + z * z);
      r28[0][1] = 2 * (x * y - w * z);
      r28[0][2] = 2 * (x * z + w * y);
      r28[1][0] = 2 * (x * y + w * z);
      r28[1][1] = one - 2 * (x * x + z * z);
      r28[1][2] = 2 * (y * z - w * x);
      r28[2][0] = 2 * (x * z - w * y);
      r28[2][1] = 2 * (y * z + w * x);
      r28[2][2] = one - 2 * (x * x + y * y);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            pv = (r28[r][c] + 2048) >>> 12;
            lv = j.scale[c];
            loc[r][c] = clamp32((pv * lv + 32768) >>> 16);
         end
         loc[r][3] = j.trans[r];
      end
      if (j.parent >= 0 && j.parent < $signed({2'b00, joint_idx})) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               acc = 0;
               for (int k = 0; k < 3; k++) begin
                  pv = pose_store[j.parent][r * 4 + k];
                  lv = loc[k][c];
                  acc += pv * lv;
               end
               acc = (acc + 32768) >>> 16;
               if (c == 3) begin
                  pv = pose_store[j.parent][r * 4 + 3];
                  acc += pv;
               end
               res[r][c] = clamp32(acc);
            end
         end
      end else begin
         res = loc;
      end
      for (int i = 0; i < NUM_WORDS; i++) begin
         pose_store[joint_idx][i] = res[i / 4][i % 4];
         pose[i] = res[i / 4][i % 4];
      end
      joint_idx = j.last ? 8'd0 : joint_idx + 8'd1;
      return pose;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("joint_trs_forward_kinematics_core_test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      pose_type seen, want;
      seen = {rsp_m23, rsp_m22, rsp_m21, rsp_m20, rsp_m13, rsp_m12, rsp_m11, rsp_m10,
              rsp_m03, rsp_m02, rsp_m01, rsp_m00};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %h", seen);
         end else begin
            want = pending_poses.pop_front();
            for (int i = 0; i < NUM_WORDS; i++) begin
               if (seen[i] !== want[i]) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("m%0d%0d: expected %h, got %h", i / 4, i % 4, want[i], seen[i]);
                  end
               end
            end
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic send_joint(input joint_type j);
      req_valid        <= 1'b1;
      req_parent_index <= j.parent;
      req_trans_x      <= j.trans[0];
      req_trans_y      <= j.trans[1];
      req_trans_z      <= j.trans[2];
      req_rot_x        <= j.quat[0];
      req_rot_y        <= j.quat[1];
      req_rot_z        <= j.quat[2];
      req_rot_w        <= j.quat[3];
      req_scale_x      <= j.scale[0];
      req_scale_y      <= j.scale[1];
      req_scale_z      <= j.scale[2];
      req_last_joint   <= j.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_poses.push_back(compose_model_matrix(j));
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_poses.size() > 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_q16();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return 32'sh00010000;
      endcase
   endfunction

   function automatic joint_type make_joint(input logic signed [8:0] parent, input bit last);
      joint_type j;
      j.parent = parent;
      j.last = last;
      for (int i = 0; i < 3; i++) begin
         j.trans[i] = pick_q16();
         j.scale[i] = pick_q16();
      end
      for (int i = 0; i < 4; i++) begin
         j.quat[i] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                   : 16'($signed($urandom_range(0, 32768)) - 16384);
      end
      return j;
   endfunction

   function automatic joint_type fixed_joint(input logic signed [8:0] parent,
                                             input logic signed [15:0] qx, qy, qz, qw,
                                             input logic signed [31:0] tv, sv, input bit last);
      joint_type j;
      j = make_joint(parent, last);
      j.quat = '{qx, qy, qz, qw};
      j.trans = '{tv, tv, tv};
      j.scale = '{sv, sv, sv};
      return j;
   endfunction

   task automatic run_skeleton(input int length, input bit closed);
      logic signed [8:0] parent;
      for (int i = 0; i < length; i++) begin
         if (joint_idx > 0 && $urandom_range(0, 99) < 85) begin
            parent = 9'($urandom_range(0, joint_idx - 1));
         end else begin
            parent = 9'($urandom);
         end
         send_joint(make_joint(parent, (closed && i == length - 1) ||
                                       $urandom_range(0, 99) < 2));
      end
   endtask

   task automatic test_roots_and_extremes();
      send_joint(fixed_joint(-9'sd1, 0, 0, 0, 16384, 0, 32'sh00010000, 1'b0));
      send_joint(fixed_joint(-9'sd1, 16384, 16384, 16384, 16384, 32'sh7fffffff,
                             32'sh7fffffff, 1'b0));
      send_joint(fixed_joint(-9'sd1, -16384, -16384, -16384, -16384, 32'sh80000000,
                             32'sh80000000, 1'b0));
      send_joint(fixed_joint(9'sd0, 100, -200, 300, 5000, 32'sh00030000, 32'sh00008000, 1'b0));
      send_joint(fixed_joint(9'sd3, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 32'sh80000000,
                             32'sh7fffffff, 1'b1));
   endtask

   task automatic test_parent_cases();
      send_joint(fixed_joint(-9'sd1, 0, 0, 11585, 11585, 32'sh00020000, 32'sh00010000, 1'b0));
      send_joint(fixed_joint(9'sd0, 11585, 0, 0, 11585, 32'sh00010000, 32'sh00020000, 1'b0));
      send_joint(fixed_joint(9'sd1, 0, 11585, 0, 11585, 32'shffff0000, 32'sh00018000, 1'b0));
      send_joint(fixed_joint(9'sd3, 0, 0, 0, 16384, 32'sh00050000, 32'sh00010000, 1'b0));
      send_joint(fixed_joint(9'sd255, 0, 0, 0, 16384, 32'sh00010000, 32'sh00010000, 1'b0));
      send_joint(fixed_joint(-9'sd256, 1000, 2000, 3000, 4000, 32'sh00010000, 32'sh7fffffff,
                             1'b0));
      send_joint(fixed_joint(9'sd2, 16384, 16384, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
      send_joint(fixed_joint(9'sd6, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000, 1'b1));
      send_joint(fixed_joint(9'sd0, 0, 0, 0, 16384, 32'sh00010000, 32'sh00010000, 1'b1));
   endtask

   task automatic test_backpressure();
      wait_drain();
      hold_cycles = 600;
      run_skeleton(12, 1'b1);
      wait_drain();
   endtask

   task automatic test_counter_wrap();
      logic signed [8:0] parent;
      for (int i = 0; i < JOINT_COUNT + 6; i++) begin
         parent = (joint_idx > 0) ? 9'($urandom_range(0, joint_idx - 1)) : -9'sd1;
         send_joint(make_joint(parent, 1'b0));
      end
      send_joint(make_joint(-9'sd1, 1'b1));
   endtask

   task automatic test_random_skeletons();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 17 : 0;
         repeat (4) run_skeleton($urandom_range(1, 12), 1'b1);
      end
   endtask

   initial begin
      send_idle_pct = 17;
      recv_idle_pct = 53;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_roots_and_extremes();
      test_parent_cases();
      test_backpressure();
      test_random_skeletons();
      send_idle_pct = 17;
      recv_idle_pct = 53;
      test_counter_wrap();
      test_random_skeletons();
      wait_drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_poses.size() == 0) begin
         $display("joint_trs_forward_kinematics_core_test passed");
      end else begin
         $display("joint_trs_forward_kinematics_core_test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/jtfk_pkg.sv
hdl/joint_trs_forward_kinematics_core.sv
tb/joint_trs_forward_kinematics_core_test.sv
